// File: rtl/core/dcbd_pkg.sv
// Shared widths, limits, mode codes and the request word for the day count block.
package dcbd_pkg;

   localparam int MODE_W  = 2;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;

   // Years above this limit saturate to it.
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   localparam logic [MODE_W-1:0] MODE_ACTUAL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_30360_US = 2'd1;
   localparam logic [MODE_W-1:0] MODE_30360_EU = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOLEAP   = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [YEAR_W-1:0]  end_year;
      logic [MONTH_W-1:0] end_month;
      logic [DAY_W-1:0]   end_day;
   } req_word_type;

endpackage

// File: rtl/core/dcbd_req_if.sv
// Request channel interface: valid, ready and the two dates with their mode.
interface dcbd_req_if import dcbd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [YEAR_W-1:0]  start_year;
   logic [MONTH_W-1:0] start_month;
   logic [DAY_W-1:0]   start_day;
   logic [YEAR_W-1:0]  end_year;
   logic [MONTH_W-1:0] end_month;
   logic [DAY_W-1:0]   end_day;

   modport source (
      output valid, mode, start_year, start_month, start_day, end_year, end_month, end_day,
      input  ready
   );
   modport sink (
      input  valid, mode, start_year, start_month, start_day, end_year, end_month, end_day,
      output ready
   );
endinterface

// File: rtl/core/dcbd_rsp_if.sv
// Response channel interface: valid, ready and the signed day count.
interface dcbd_rsp_if import dcbd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COUNT_W-1:0] day_count;

   modport source (output valid, day_count, input ready);
   modport sink   (input valid, day_count, output ready);
endinterface

// File: rtl/core/day_count_between_dates.sv
// Top level of the day count block: two-stage pipeline from date pair to signed day count.
//
// This block takes one request word per cycle, each holding a start date, an end date and
// a convention mode, and returns one response word with the signed number of days from
// the start date to the end date. Mode actual uses proleptic Gregorian serial days (year 0
// is a leap year), the two 30/360 modes (US and European) count 30-day months and 360-day
// years with the sign of the original date order, and mode no-leap counts 365-day years
// with Feb 29 read as Feb 28. Years above 9999 saturate to 9999. It accepts one word per
// clock cycle while the response side is not stalled. A request word is held in the input
// register and its result in the result register, around one pass of date arithmetic.
// A stalled response holds the pipeline: each register only advances when the stage after
// it is empty or being drained in the same cycle.
module day_count_between_dates import dcbd_pkg::*; (
   input  logic clock,
   input  logic reset,
   dcbd_req_if.sink   req_bus,
   dcbd_rsp_if.source rsp_bus
);

   // Cumulative days before each month of a common year. Month 0 behaves like January.
   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      case (m)
         4'd2:    cum_days = 9'd31;
         4'd3:    cum_days = 9'd59;
         4'd4:    cum_days = 9'd90;
         4'd5:    cum_days = 9'd120;
         4'd6:    cum_days = 9'd151;
         4'd7:    cum_days = 9'd181;
         4'd8:    cum_days = 9'd212;
         4'd9:    cum_days = 9'd243;
         4'd10:   cum_days = 9'd273;
         4'd11:   cum_days = 9'd304;
         4'd12:   cum_days = 9'd334;
         default: cum_days = 9'd0;
      endcase
   endfunction

   // Division by 100 through a reciprocal multiply; exact for every 14-bit value.
   function automatic logic [7:0] div100(input logic [YEAR_W-1:0] x);
      logic [26:0] prod;
      prod   = 27'(x) * 27'd5243;
      div100 = prod[26:19];
   endfunction

   function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
      clamp_year = (y > YEAR_MAX) ? YEAR_MAX : y;
   endfunction

   // Gregorian serial day number. Months 13 to 15 carry into the next year.
   function automatic logic [21:0] serial_day(input logic [YEAR_W-1:0]  y_in,
                                              input logic [MONTH_W-1:0] m_in,
                                              input logic [DAY_W-1:0]   d);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [7:0]         q_y;
      logic [YEAR_W-1:0]  rem_y;
      logic               is_leap;
      logic [21:0]        s;
      y = y_in;
      m = m_in;
      if (m > 4'd12) begin
         m = m - 4'd12;
         y = y + 14'd1;
      end
      q_y     = div100(y);
      rem_y   = y - YEAR_W'(q_y) * 14'd100;
      is_leap = (y[1:0] == 2'd0) && ((rem_y != '0) || (q_y[1:0] == 2'd0));
      s = 22'(y) * 22'd365
        + 22'((y + 14'd3) >> 2)
        - 22'(div100(y + 14'd99))
        + 22'(div100((y + 14'd399) >> 2))
        + 22'(cum_days(m))
        + 22'(d);
      if (is_leap && (m > 4'd2)) begin
         s = s + 22'd1;
      end
      serial_day = s;
   endfunction

   // Day number in a calendar of 365-day years.
   function automatic logic [21:0] noleap_day(input logic [YEAR_W-1:0]  y_in,
                                              input logic [MONTH_W-1:0] m_in,
                                              input logic [DAY_W-1:0]   d_in);
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      y = y_in;
      m = m_in;
      d = d_in;
      if (m > 4'd12) begin
         m = m - 4'd12;
         y = y + 14'd1;
      end
      if ((m == 4'd2) && (d == 5'd29)) begin
         d = 5'd28;
      end
      noleap_day = 22'(y) * 22'd365 + 22'(cum_days(m)) + 22'(d);
   endfunction

   // 30/360 count. The dates are ordered first and the sign restored at the end.
   function automatic logic [COUNT_W-1:0] thirty_360(input req_word_type w,
                                                     input logic         eur);
      logic [YEAR_W-1:0]  y0, y1;
      logic [MONTH_W-1:0] m0;
      logic [4:0]         m1;
      logic [DAY_W-1:0]   d0, d1;
      logic               earlier;
      logic signed [23:0] dy, dm, dd, r;
      y0 = clamp_year(w.start_year);
      y1 = clamp_year(w.end_year);
      earlier = (y0 < y1) ||
                ((y0 == y1) && ((w.start_month < w.end_month) ||
                 ((w.start_month == w.end_month) && (w.start_day < w.end_day))));
      if (earlier) begin
         m0 = w.start_month;
         d0 = w.start_day;
         m1 = {1'b0, w.end_month};
         d1 = w.end_day;
      end else begin
         y0 = clamp_year(w.end_year);
         y1 = clamp_year(w.start_year);
         m0 = w.end_month;
         d0 = w.end_day;
         m1 = {1'b0, w.start_month};
         d1 = w.start_day;
      end
      if (!eur && (d1 == 5'd31) && (d0 < 5'd30)) begin
         m1 = m1 + 5'd1;
         d1 = 5'd1;
      end
      if (d0 == 5'd31) begin
         d0 = 5'd30;
      end
      if (d1 == 5'd31) begin
         d1 = 5'd30;
      end
      dy = $signed({10'd0, y1}) - $signed({10'd0, y0});
      dm = $signed({19'd0, m1}) - $signed({20'd0, m0});
      dd = $signed({19'd0, d1}) - $signed({19'd0, d0});
      r  = dy * 24'sd360 + dm * 24'sd30 + dd;
      if (!earlier) begin
         r = -r;
      end
      thirty_360 = r[COUNT_W-1:0];
   endfunction

   // Stage 1: the registered request word.
   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   req_word_type req_word;

   // Stage 2: the registered result.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic rsp_open;   // the result register can take a new value this cycle
   logic s1_open;    // the input register can take a new word this cycle
   logic req_fire;
   logic s1_move;

   assign req_word = '{mode:        req_bus.mode,
                       start_year:  req_bus.start_year,
                       start_month: req_bus.start_month,
                       start_day:   req_bus.start_day,
                       end_year:    req_bus.end_year,
                       end_month:   req_bus.end_month,
                       end_day:     req_bus.end_day};

   assign rsp_open = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move  = s1_valid_ff && rsp_open;
   assign s1_open  = !s1_valid_ff || rsp_open;
   assign req_fire = req_bus.valid && s1_open;

   assign req_bus.ready     = s1_open;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.day_count = rsp_count_ff;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   // The whole day count is one pass of closed-form arithmetic on the stage 1 word.
   always_comb begin
      case (s1_word_ff.mode)
         MODE_30360_US: rsp_count_in = $signed(thirty_360(s1_word_ff, 1'b0));
         MODE_30360_EU: rsp_count_in = $signed(thirty_360(s1_word_ff, 1'b1));
         MODE_NOLEAP: begin
            rsp_count_in = $signed(
               {1'b0, noleap_day(clamp_year(s1_word_ff.end_year), s1_word_ff.end_month,
                                 s1_word_ff.end_day)} -
               {1'b0, noleap_day(clamp_year(s1_word_ff.start_year), s1_word_ff.start_month,
                                 s1_word_ff.start_day)});
         end
         default: begin
            rsp_count_in = $signed(
               {1'b0, serial_day(clamp_year(s1_word_ff.end_year), s1_word_ff.end_month,
                                 s1_word_ff.end_day)} -
               {1'b0, serial_day(clamp_year(s1_word_ff.start_year), s1_word_ff.start_month,
                                 s1_word_ff.start_day)});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff <= req_word;
      end
      if (s1_move) begin
         rsp_count_ff <= rsp_count_in;
      end
   end

   // An accepted word always lands in stage 1.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request word did not reach stage 1");

   // A stage 1 word held behind a stalled result must still be there next cycle.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_open) |=> (s1_valid_ff && $stable(s1_word_ff)))
      else $error("stage 1 word lost during a response stall");

   // A stage 1 word that moves on shows up as a valid response.
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("stage 1 word did not produce a response");

   // Equal dates in a 30/360 mode give a count of zero.
   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_move &&
       ((s1_word_ff.mode == MODE_30360_US) || (s1_word_ff.mode == MODE_30360_EU)) &&
       (s1_word_ff.start_year == s1_word_ff.end_year) &&
       (s1_word_ff.start_month == s1_word_ff.end_month) &&
       (s1_word_ff.start_day == s1_word_ff.end_day))
      |=> (rsp_count_ff == '0))
      else $error("equal dates gave a nonzero 30/360 count");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the day count block: directed and random date pairs.
`timescale 1ns / 1ps

module tb;
   import dcbd_pkg::*;

   // Number of random words sent in each of the three idling phases.
   localparam int RANDOM_PER_PHASE = 510;
   // Length of the single long response stall in the last phase.
   localparam int HOLD_CYCLES = 40;
   // Days in the months before month m of a common year; entry 0 stands for month 0.
   localparam int DAYS_BEFORE_MONTH [13] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   // One row of the directed table. When count_given is set, the expected count is
   // written into the row; otherwise it comes from the predictor below.
   typedef struct {
      req_word_type       word;
      bit                 count_given;
      logic [COUNT_W-1:0] count;
   } calendar_case_type;

   // An expected response, kept with the request word that caused it for reporting.
   typedef struct {
      req_word_type       word;
      logic [COUNT_W-1:0] count;
   } expected_count_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcbd_req_if req_bus ();
   dcbd_rsp_if rsp_bus ();

   day_count_between_dates dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   calendar_case_type  calendar_cases[$];
   expected_count_type expected_counts[$];
   int                 mismatch_count = 0;
   int unsigned        sender_idle_pct = 15;
   int unsigned        receiver_idle_pct = 73;
   bit                 hold_request = 1'b0;
   bit                 hold_done = 1'b0;

   always #1 clock = ~clock;

   // Reset is held at the start and then released for good.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: the slowest correct run takes well under a tenth of this time.
   initial begin
      #1_000_000;
      $display("day_count_between_dates: mismatch");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] %s", $time, msg);
      mismatch_count++;
   endtask

   // Proleptic Gregorian serial day. Months 13 to 15 carry into the next year, so the
   // year may reach one past the limit here. Year 0 is a leap year.
   function automatic longint gregorian_day(longint y, longint m, longint d);
      longint serial;
      if (m > 12) begin
         m -= 12;
         y += 1;
      end
      serial = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
               + DAYS_BEFORE_MONTH[m];
      if ((((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) && m > 2) begin
         serial += 1;
      end
      return serial + d;
   endfunction

   // Serial day in a calendar without leap days; Feb 29 reads as Feb 28 once the month
   // has been brought into range.
   function automatic longint noleap_day(longint y, longint m, longint d);
      if (m > 12) begin
         m -= 12;
         y += 1;
      end
      if (m == 2 && d == 29) begin
         d = 28;
      end
      return 365 * y + DAYS_BEFORE_MONTH[m] + d;
   endfunction

   // Expected day count for one request word, truncated to the width of the result.
   function automatic logic [COUNT_W-1:0] predict_day_count(input req_word_type w);
      longint y0, m0, d0, y1, m1, d1, t, sign, count;
      bit     earlier;
      y0 = (w.start_year > YEAR_MAX) ? YEAR_MAX : w.start_year;
      m0 = w.start_month;
      d0 = w.start_day;
      y1 = (w.end_year > YEAR_MAX) ? YEAR_MAX : w.end_year;
      m1 = w.end_month;
      d1 = w.end_day;
      case (w.mode)
         MODE_30360_US, MODE_30360_EU: begin
            // Order the dates as (year, month, day) and remember the original sign.
            earlier = (y0 < y1) || (y0 == y1 && (m0 < m1 || (m0 == m1 && d0 < d1)));
            sign = earlier ? 1 : -1;
            if (!earlier) begin
               t = y0; y0 = y1; y1 = t;
               t = m0; m0 = m1; m1 = t;
               t = d0; d0 = d1; d1 = t;
            end
            // US rule: an end on the 31st after a start before the 30th rolls over to
            // the first of the next month.
            if (w.mode == MODE_30360_US && d1 == 31 && d0 < 30) begin
               m1 += 1;
               d1 = 1;
            end
            if (d0 == 31) begin
               d0 = 30;
            end
            if (d1 == 31) begin
               d1 = 30;
            end
            count = sign * (360 * (y1 - y0) + 30 * (m1 - m0) + d1 - d0);
         end
         MODE_NOLEAP: begin
            count = noleap_day(y1, m1, d1) - noleap_day(y0, m0, d0);
         end
         default: begin
            count = gregorian_day(y1, m1, d1) - gregorian_day(y0, m0, d0);
         end
      endcase
      return count[COUNT_W-1:0];
   endfunction

   // A legal day of the given month, biased toward the last days so that the 30/360
   // end-of-month rules and Feb 29 are hit often.
   function automatic logic [DAY_W-1:0] random_day(int unsigned y, int unsigned m);
      int unsigned last;
      if (m == 2) begin
         last = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
      end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
         last = 30;
      end else begin
         last = 31;
      end
      if ($urandom_range(99) < 40) begin
         return DAY_W'($urandom_range(last, last - 2));
      end
      return DAY_W'($urandom_range(last, 1));
   endfunction

   // Most random words are legal date pairs: equal dates, dates in the same year, dates
   // a few years apart and dates far apart. The rest are noise over the full width of
   // every field, which brings in saturated years, months 0 and 13 to 15, and day 0.
   function automatic req_word_type random_request();
      req_word_type w;
      int unsigned  shape, lo, hi;
      shape = $urandom_range(99);
      w.mode = MODE_W'($urandom_range(3));
      if (shape < 12) begin
         w.start_year  = YEAR_W'($urandom);
         w.start_month = MONTH_W'($urandom);
         w.start_day   = DAY_W'($urandom);
         w.end_year    = YEAR_W'($urandom);
         w.end_month   = MONTH_W'($urandom);
         w.end_day     = DAY_W'($urandom);
         return w;
      end
      w.start_year  = YEAR_W'($urandom_range(9999));
      w.start_month = MONTH_W'($urandom_range(12, 1));
      w.start_day   = random_day(w.start_year, w.start_month);
      if (shape < 20) begin
         w.end_year  = w.start_year;
         w.end_month = w.start_month;
         w.end_day   = w.start_day;
         return w;
      end
      if (shape < 55) begin
         w.end_year = w.start_year;
      end else if (shape < 80) begin
         lo = (w.start_year > 3) ? w.start_year - 3 : 0;
         hi = (w.start_year < 9996) ? w.start_year + 3 : 9999;
         w.end_year = YEAR_W'($urandom_range(hi, lo));
      end else begin
         w.end_year = YEAR_W'($urandom_range(9999));
      end
      w.end_month = MONTH_W'($urandom_range(12, 1));
      w.end_day   = random_day(w.end_year, w.end_month);
      return w;
   endfunction

   task automatic add_case(input logic [MODE_W-1:0] mode,
                           input int sy, input int sm, input int sd,
                           input int ey, input int em, input int ed,
                           input bit count_given, input int count);
      calendar_case_type c;
      c.word.mode        = mode;
      c.word.start_year  = sy[YEAR_W-1:0];
      c.word.start_month = sm[MONTH_W-1:0];
      c.word.start_day   = sd[DAY_W-1:0];
      c.word.end_year    = ey[YEAR_W-1:0];
      c.word.end_month   = em[MONTH_W-1:0];
      c.word.end_day     = ed[DAY_W-1:0];
      c.count_given      = count_given;
      c.count            = count[COUNT_W-1:0];
      calendar_cases.push_back(c);
   endtask

   // Offers one request word, possibly after a few idle cycles, and returns at the edge
   // where it is accepted. Valid stays high on return, so a word that follows at once
   // is driven without valid dropping in between.
   task automatic send_request(input req_word_type w, input bit count_given,
                               input logic [COUNT_W-1:0] count);
      expected_count_type e;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      {req_bus.mode, req_bus.start_year, req_bus.start_month, req_bus.start_day,
       req_bus.end_year, req_bus.end_month, req_bus.end_day} <= w;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      e.word  = w;
      e.count = count_given ? count : predict_day_count(w);
      expected_counts.push_back(e);
   endtask

   // Response side: random back-pressure, plus one long stall in the last phase that
   // fills the pipeline and stalls the request side while words keep being offered.
   initial begin : response_ready
      int held;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_done = 1'b1;
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Every accepted response word is checked against the oldest expectation.
   always @(posedge clock) begin : check_responses
      expected_count_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_counts.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request outstanding",
                                      rsp_bus.day_count));
         end else begin
            want = expected_counts.pop_front();
            if (rsp_bus.day_count !== want.count) begin
               report_mismatch($sformatf(
                  "mode %0d %0d-%0d-%0d to %0d-%0d-%0d: day_count %0d, expected %0d",
                  want.word.mode, want.word.start_year, want.word.start_month,
                  want.word.start_day, want.word.end_year, want.word.end_month,
                  want.word.end_day, rsp_bus.day_count, $signed(want.count)));
            end
         end
      end
   end

   initial begin : stimulus
      req_bus.valid <= 1'b0;
      {req_bus.mode, req_bus.start_year, req_bus.start_month, req_bus.start_day,
       req_bus.end_year, req_bus.end_month, req_bus.end_day} <= '0;

      // Directed table. Actual mode: same day, the first year after year 0, the full
      // year range both ways, a saturated year, month 13 and month 0, day offsets past
      // the month end and day 0, and Feb 28 to Mar 1 in a leap year and a non-leap century year.
      add_case(MODE_ACTUAL,    2000,  1,  1, 2000,  1,  1, 1, 0);
      add_case(MODE_ACTUAL,       0,  1,  1,    1,  1,  1, 1, 366);
      add_case(MODE_ACTUAL,       0,  1,  1, 9999, 12, 31, 0, 0);
      add_case(MODE_ACTUAL,    9999, 12, 31,    0,  1,  1, 0, 0);
      add_case(MODE_ACTUAL,   16383,  1,  1, 9999,  1,  1, 1, 0);
      add_case(MODE_ACTUAL,    2023, 13,  1, 2024,  1,  1, 1, 0);
      add_case(MODE_ACTUAL,    2023,  0,  5, 2023,  1,  5, 1, 0);
      add_case(MODE_ACTUAL,    9999, 15, 31,    0,  0,  0, 0, 0);
      add_case(MODE_ACTUAL,    2023,  2, 31, 2023,  3,  3, 1, 0);
      add_case(MODE_ACTUAL,    2024,  3,  0, 2024,  2, 29, 1, 0);
      add_case(MODE_ACTUAL,    2024,  2, 28, 2024,  3,  1, 1, 2);
      add_case(MODE_ACTUAL,    1900,  2, 28, 1900,  3,  1, 1, 1);
      // 30/360 modes: the US and European end-of-month rules, reversed order, equal
      // dates, months out of range and the widest span.
      add_case(MODE_30360_US,  2023,  1, 31, 2023,  2, 28, 1, 28);
      add_case(MODE_30360_US,  2023,  1, 15, 2023,  3, 31, 1, 76);
      add_case(MODE_30360_EU,  2023,  1, 15, 2023,  3, 31, 1, 75);
      add_case(MODE_30360_US,  2023,  3, 31, 2023,  1, 15, 1, -76);
      add_case(MODE_30360_EU,  2023,  7,  4, 2023,  7,  4, 1, 0);
      add_case(MODE_30360_US,  2023, 15,  0, 2023,  0, 31, 0, 0);
      add_case(MODE_30360_US,     0,  1,  1, 16383, 12, 31, 0, 0);
      add_case(MODE_30360_EU,  2023,  5, 31, 2023,  7, 31, 1, 60);
      add_case(MODE_30360_US,  2023,  5, 31, 2023,  7, 31, 1, 60);
      // No-leap mode: one year is 365 days, Feb 29 reads as Feb 28, also after a
      // month of 14 has carried into February of the next year.
      add_case(MODE_NOLEAP,    2023,  1,  1, 2024,  1,  1, 1, 365);
      add_case(MODE_NOLEAP,    2024,  2, 29, 2024,  2, 28, 1, 0);
      add_case(MODE_NOLEAP,    2023, 14, 29, 2024,  2, 28, 1, 0);
      add_case(MODE_NOLEAP,       0,  0,  0, 16383, 15, 31, 0, 0);

      while (reset) begin
         @(posedge clock);
      end

      // The directed words run under the first idling pattern.
      foreach (calendar_cases[i]) begin
         send_request(calendar_cases[i].word, calendar_cases[i].count_given,
                      calendar_cases[i].count);
      end

      // Three random phases: a mostly busy sender against a slow receiver, then the
      // reverse, then both sides at full rate with one long response stall.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 15;
               receiver_idle_pct = 73;
            end
            1: begin
               sender_idle_pct = 73;
               receiver_idle_pct = 15;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            send_request(random_request(), 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      // Drain the pipeline, then keep the clock running so that any stray word shows.
      while (expected_counts.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("day_count_between_dates: match");
      end else begin
         $display("day_count_between_dates: mismatch");
      end
      $finish;
   end

endmodule

// File: day_count_between_dates.f
rtl/core/dcbd_pkg.sv
rtl/core/dcbd_req_if.sv
rtl/core/dcbd_rsp_if.sv
rtl/core/day_count_between_dates.sv
dv/tb.sv
